[sv/lfucr_pkg.sv]
// ----------------------------------------------------------------------------
// lfucr_pkg
// Shared types and constants of the LFU cache with LRU tie break.
// ----------------------------------------------------------------------------
package lfucr_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam int COUNT_BITS_DEF = 16;

	localparam int         CAP_W     = 5;
	localparam logic [4:0] CAP_RESET = 5'd16;
	localparam int         CMP_W     = 7;
	localparam int         ADDR_W    = 2;
	localparam int         DATA_W    = 32;

	localparam logic [ADDR_W-1:0] REG_CAPACITY = 2'd0;

	typedef enum logic [1:0] {
		CELL_NOP,
		CELL_TOUCH,
		CELL_EVICT,
		CELL_INSERT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     wr_data;
	} cell_cmd_t;

endpackage

[sv/lfucr_cell.sv]
// ----------------------------------------------------------------------------
// lfucr_cell
// One cache slot: key, value, use count and recency rank, updated by a
// command that is broadcast to the whole row of slots.
// ----------------------------------------------------------------------------
module lfucr_cell #(
	parameter int ENTRIES    = lfucr_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = lfucr_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lfucr_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = lfucr_pkg::COUNT_BITS_DEF,
	localparam int RW        = $clog2(ENTRIES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lfucr_pkg::cell_cmd_t  cmd,
	input  logic                  sel,
	input  logic [RW-1:0]         ref_rank,
	input  logic [KEY_BITS-1:0]   wkey,
	input  logic [VALUE_BITS-1:0] wdata,
	output logic                  valid,
	output logic [KEY_BITS-1:0]   key,
	output logic [VALUE_BITS-1:0] data,
	output logic [COUNT_BITS-1:0] count,
	output logic [RW-1:0]         rank
);

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] data_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [RW-1:0]         rank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (cmd.op == lfucr_pkg::CELL_EVICT && sel) begin
				valid_q <= 1'b0;
			end else if (cmd.op == lfucr_pkg::CELL_INSERT && sel) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			lfucr_pkg::CELL_TOUCH: begin
				if (sel) begin
					rank_q <= '0;
					if (count_q != '1) begin
						count_q <= count_q + 1'b1;
					end
					if (cmd.wr_data) begin
						data_q <= wdata;
					end
				end else if (valid_q && rank_q < ref_rank) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			lfucr_pkg::CELL_EVICT: begin
				if (!sel && valid_q && rank_q > ref_rank) begin
					rank_q <= rank_q - 1'b1;
				end
			end
			lfucr_pkg::CELL_INSERT: begin
				if (sel) begin
					key_q   <= wkey;
					data_q  <= wdata;
					count_q <= COUNT_BITS'(1);
					rank_q  <= '0;
				end else if (valid_q) begin
					rank_q <= rank_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign valid = valid_q;
	assign key   = key_q;
	assign data  = data_q;
	assign count = count_q;
	assign rank  = rank_q;

endmodule

[sv/lfu_cache_replacement.sv]
// ----------------------------------------------------------------------------
// lfu_cache_replacement
// Fully associative key/value cache with LFU replacement and LRU tie break.
// ----------------------------------------------------------------------------
// A request (req_type, req_key, write_value) is a transfer on the input
// channel; every request yields one result transfer (hit, read_value,
// evicted, evicted_key) on the output channel. One request is worked on at
// a time, and in_stall stays high until its result sits in the output
// register. A put miss at full capacity walks the row of slots one slot per
// cycle to find the victim; that walk sets the worst-case rate while
// out_stall is low. The result is offered in the same cycle in which
// in_stall drops. The output register holds it while out_stall is high; a
// new request may be accepted meanwhile, but its result waits until the
// register is free. Reset empties all slots and sets capacity_in_use to 16.
// The user must write capacity_in_use through the APB port at address 0
// only while no request is in flight; the block leaves this check to the user.
// ----------------------------------------------------------------------------
module lfu_cache_replacement #(
	parameter int ENTRIES    = lfucr_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = lfucr_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lfucr_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = lfucr_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lfucr_pkg::ADDR_W-1:0]   paddr,
	input  logic [lfucr_pkg::DATA_W-1:0]   pwdata,
	output logic [lfucr_pkg::DATA_W-1:0]   prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           req_type,
	input  logic [KEY_BITS-1:0]            req_key,
	input  logic [VALUE_BITS-1:0]          write_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic [VALUE_BITS-1:0]          read_value,
	output logic                           evicted,
	output logic [KEY_BITS-1:0]            evicted_key
);

	localparam int RW = $clog2(ENTRIES);
	localparam int UW = $clog2(ENTRIES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_EVICT,
		ST_INSERT,
		ST_RESP
	} state_t;

	state_t                          state_q;
	logic [lfucr_pkg::CAP_W-1:0]     cap_q;
	logic                            is_put_q;
	logic [KEY_BITS-1:0]             key_q;
	logic [VALUE_BITS-1:0]           val_q;
	logic [RW-1:0]                   idx_q;
	logic                            cand_vld_q;
	logic [RW-1:0]                   cand_idx_q;
	logic [COUNT_BITS-1:0]           cand_cnt_q;
	logic [RW-1:0]                   cand_rank_q;
	logic                            res_hit_q;
	logic [VALUE_BITS-1:0]           res_val_q;
	logic                            res_ev_q;
	logic [KEY_BITS-1:0]             res_key_q;
	logic                            out_valid_q;
	logic                            hit_q;
	logic [VALUE_BITS-1:0]           read_value_q;
	logic                            evicted_q;
	logic [KEY_BITS-1:0]             evicted_key_q;

	logic [ENTRIES-1:0]              c_valid;
	logic [KEY_BITS-1:0]             c_key   [ENTRIES];
	logic [VALUE_BITS-1:0]           c_data  [ENTRIES];
	logic [COUNT_BITS-1:0]           c_count [ENTRIES];
	logic [RW-1:0]                   c_rank  [ENTRIES];

	lfucr_pkg::cell_cmd_t            cmd;
	logic [RW-1:0]                   sel_idx;
	logic [RW-1:0]                   ref_rank;
	logic                            found;
	logic [RW-1:0]                   found_idx;
	logic                            free_ok;
	logic [RW-1:0]                   free_idx;
	logic [UW-1:0]                   used;
	logic [lfucr_pkg::CMP_W-1:0]     cap_x;
	logic [lfucr_pkg::CMP_W-1:0]     lim;
	logic                            full;
	logic                            better;
	logic                            cfg_wr;

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			lfucr_cell #(
				.ENTRIES    (ENTRIES),
				.KEY_BITS   (KEY_BITS),
				.VALUE_BITS (VALUE_BITS),
				.COUNT_BITS (COUNT_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.sel      (sel_idx == RW'(g)),
				.ref_rank (ref_rank),
				.wkey     (key_q),
				.wdata    (val_q),
				.valid    (c_valid[g]),
				.key      (c_key[g]),
				.data     (c_data[g]),
				.count    (c_count[g]),
				.rank     (c_rank[g])
			);
		end
	endgenerate

	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		free_ok   = 1'b0;
		free_idx  = '0;
		used      = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (c_valid[i] && c_key[i] == key_q) begin
				found     = 1'b1;
				found_idx = RW'(i);
			end
			if (!c_valid[i]) begin
				free_ok  = 1'b1;
				free_idx = RW'(i);
			end
		end
		for (int i = 0; i < ENTRIES; i++) begin
			used = used + UW'(c_valid[i]);
		end
	end

	assign cap_x = (cap_q == '0) ? lfucr_pkg::CMP_W'(1) : lfucr_pkg::CMP_W'(cap_q);
	assign lim   = (cap_x > lfucr_pkg::CMP_W'(ENTRIES)) ? lfucr_pkg::CMP_W'(ENTRIES) : cap_x;
	assign full  = lfucr_pkg::CMP_W'(used) >= lim;

	assign better = c_valid[idx_q] && (!cand_vld_q || c_count[idx_q] < cand_cnt_q ||
		(c_count[idx_q] == cand_cnt_q && c_rank[idx_q] > cand_rank_q));

	always_comb begin
		cmd.op      = lfucr_pkg::CELL_NOP;
		cmd.wr_data = 1'b0;
		sel_idx     = found_idx;
		ref_rank    = c_rank[found_idx];
		unique case (state_q)
			ST_LOOK: begin
				if (found) begin
					cmd.op      = lfucr_pkg::CELL_TOUCH;
					cmd.wr_data = is_put_q;
				end
			end
			ST_EVICT: begin
				cmd.op   = lfucr_pkg::CELL_EVICT;
				sel_idx  = cand_idx_q;
				ref_rank = cand_rank_q;
			end
			ST_INSERT: begin
				sel_idx = free_idx;
				if (free_ok) begin
					cmd.op = lfucr_pkg::CELL_INSERT;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			cand_vld_q  <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					res_hit_q <= found;
					res_val_q <= (found && !is_put_q) ? c_data[found_idx] : '0;
					res_ev_q  <= 1'b0;
					res_key_q <= '0;
					idx_q     <= '0;
					cand_vld_q <= 1'b0;
					if (found || !is_put_q) begin
						state_q <= ST_RESP;
					end else if (full) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_INSERT;
					end
				end
				ST_SCAN: begin
					if (better) begin
						cand_vld_q  <= 1'b1;
						cand_idx_q  <= idx_q;
						cand_cnt_q  <= c_count[idx_q];
						cand_rank_q <= c_rank[idx_q];
					end
					if (idx_q == RW'(ENTRIES - 1)) begin
						state_q <= ST_EVICT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EVICT: begin
					res_ev_q  <= 1'b1;
					res_key_q <= c_key[cand_idx_q];
					state_q   <= ST_INSERT;
				end
				ST_INSERT: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						hit_q         <= res_hit_q;
						read_value_q  <= res_val_q;
						evicted_q     <= res_ev_q;
						evicted_key_q <= res_key_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			is_put_q <= req_type;
			key_q    <= req_key;
			val_q    <= write_value;
		end
	end

	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfucr_pkg::CAP_RESET;
		end else if (cfg_wr && paddr == lfucr_pkg::REG_CAPACITY) begin
			cap_q <= pwdata[lfucr_pkg::CAP_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == lfucr_pkg::REG_CAPACITY) ?
		lfucr_pkg::DATA_W'(cap_q) : '0;

	assign in_stall    = state_q != ST_IDLE;
	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign read_value  = read_value_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

endmodule
